### rtl/http_frame_boundary_finder_macros.svh
// assertion helpers shared by the rtl
`ifndef HTTP_FRAME_BOUNDARY_FINDER_MACROS_SVH
`define HTTP_FRAME_BOUNDARY_FINDER_MACROS_SVH

// same-cycle implication, ignored while in reset
`define HFBF_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hfbf same-cycle check failed");

// next-cycle implication, ignored while in reset
`define HFBF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hfbf next-cycle check failed");

`endif

### rtl/hfbf_pkg.sv
package hfbf_pkg;

    // width of the tracked buffer position
    localparam int POS_W = 32;
    // width of the offset and frame start ports
    localparam int OFFSET_W = 32;

    localparam int HIST_W = 64;
    localparam int WIN_W  = HIST_W + 8;
    localparam int FILL_W = 3;
    localparam int OFF_W  = 4;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_REQUEST  = 2'd0;
    localparam kind_t KIND_RESPONSE = 2'd1;

    // crlfcrlf, last byte in the low lane
    localparam logic [31:0] MARKER = 32'h0D0A_0D0A;
    localparam logic [FILL_W-1:0] MARKER_FILL = FILL_W'(3);

    localparam int NUM_REQ  = 9;
    localparam int NUM_RESP = 2;

    // patterns right aligned, last character in the low byte
    localparam logic [WIN_W-1:0] REQ_PAT [NUM_REQ] = '{
        WIN_W'("GET "), WIN_W'("HEAD "), WIN_W'("POST "), WIN_W'("PUT "),
        WIN_W'("DELETE "), WIN_W'("CONNECT "), WIN_W'("OPTIONS "),
        WIN_W'("TRACE "), WIN_W'("PATCH ")
    };
    localparam int REQ_LEN [NUM_REQ] = '{4, 5, 5, 4, 7, 8, 8, 6, 6};

    localparam logic [WIN_W-1:0] RESP_PAT [NUM_RESP] = '{
        WIN_W'("HTTP/1.1 "), WIN_W'("HTTP/1.0 ")
    };
    localparam int RESP_LEN [NUM_RESP] = '{9, 9};

    typedef struct packed {
        logic             hit;
        logic [OFF_W-1:0] off;   // distance back to the pattern start
    } hit_t;

    function automatic logic [WIN_W-1:0] len_mask(input int len);
        return {WIN_W{1'b1}} >> (WIN_W - 8 * len);
    endfunction

    // nearest pattern start among all patterns that end on this byte
    function automatic hit_t pick_start(input logic [WIN_W-1:0] win, input kind_t kind);
        hit_t r;
        r.hit = 1'b0;
        r.off = '0;
        case (kind)
            KIND_REQUEST: begin
                for (int i = 0; i < NUM_REQ; i++) begin
                    if ((win & len_mask(REQ_LEN[i])) == REQ_PAT[i] &&
                        (!r.hit || OFF_W'(REQ_LEN[i] - 1) < r.off)) begin
                        r.hit = 1'b1;
                        r.off = OFF_W'(REQ_LEN[i] - 1);
                    end
                end
            end
            KIND_RESPONSE: begin
                for (int i = 0; i < NUM_RESP; i++) begin
                    if ((win & len_mask(RESP_LEN[i])) == RESP_PAT[i] &&
                        (!r.hit || OFF_W'(RESP_LEN[i] - 1) < r.off)) begin
                        r.hit = 1'b1;
                        r.off = OFF_W'(RESP_LEN[i] - 1);
                    end
                end
            end
            default: begin
                r.hit = 1'b0;
            end
        endcase
        return r;
    endfunction

endpackage

### rtl/http_frame_boundary_finder.sv
// Scans a buffer one byte per transaction and reports where the HTTP message
// starts: the latest request-method or response-version pattern that lies in
// the first CRLFCRLF-terminated segment holding one. A transaction with
// s_first_byte set begins a new search at s_start_offset; later bytes count up
// from there, saturating at the top of the position range. One result comes
// out per search: found with the pattern start when a marker closes such a
// segment, or not-found (frame_start 0) at the byte flagged s_last_byte.
// Bytes after a result are dropped until the next first byte. cfg_data picks
// the pattern set (0 request, 1 response, other values never match); the user
// must write it only while the block is idle, which the block does not enforce.
// Throughput is one byte per clock while the result receiver keeps up; a byte
// goes through an input register and a compare/update stage that loads the
// output register, from which its result is presented. While a result waits
// on a stalled receiver the byte held in the input register waits too, and
// s_ready stays low until m_ready returns. The single-cycle limit is the
// compare stage: window compare, one position subtract and the latest-start compare.
`include "http_frame_boundary_finder_macros.svh"

module http_frame_boundary_finder (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    // byte input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_byte,
    input  logic [31:0] s_start_offset,
    input  logic        s_last_byte,
    // result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [31:0] m_frame_start
);

    localparam int POS_W  = hfbf_pkg::POS_W;
    localparam int HIST_W = hfbf_pkg::HIST_W;
    localparam int FILL_W = hfbf_pkg::FILL_W;

    // message kind register
    hfbf_pkg::kind_t kind_reg;

    // input stage
    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;
    logic             in_first_reg;
    logic             in_last_reg;
    logic [POS_W-1:0] pos_reg, pos_next;   // position of the latest byte taken

    // search state
    logic [HIST_W-1:0] hist_reg, hist_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [POS_W-1:0]  best_reg, best_next;
    logic              best_valid_reg, best_valid_next;
    logic              done_reg, done_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic              m_found_reg, m_found_next;
    logic [31:0]       m_start_reg, m_start_next;

    logic s_accept;
    logic proc_fire;
    logic out_load;

    // values seen by the compare stage once a first byte has cleared them
    logic [HIST_W-1:0] hist_eff;
    logic [FILL_W-1:0] fill_eff;
    logic [POS_W-1:0]  best_eff;
    logic              best_valid_eff;
    logic              done_eff;

    hfbf_pkg::hit_t    hit;
    logic [POS_W-1:0]  cand;
    logic [POS_W-1:0]  off_ext;
    logic              marker;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    // stage moves when the output register is empty or being drained
    assign proc_fire = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc_fire;
    assign s_accept  = s_valid && s_ready;

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_frame_start = m_start_reg;

    // position bookkeeping, independent of search state
    always_comb begin
        if (s_first_byte) begin
            pos_next = POS_W'(s_start_offset);
        end else if (pos_reg == {POS_W{1'b1}}) begin
            pos_next = pos_reg;
        end else begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_comb begin
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (proc_fire) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    // first byte wipes segment and done state before this byte is judged
    assign hist_eff       = in_first_reg ? '0 : hist_reg;
    assign fill_eff       = in_first_reg ? '0 : fill_reg;
    assign best_eff       = in_first_reg ? '0 : best_reg;
    assign best_valid_eff = in_first_reg ? 1'b0 : best_valid_reg;
    assign done_eff       = in_first_reg ? 1'b0 : done_reg;

    // pattern hits over the history plus current byte
    assign hit     = hfbf_pkg::pick_start({hist_eff, in_byte_reg}, kind_reg);
    assign off_ext = POS_W'(hit.off);
    assign cand    = (pos_reg >= off_ext) ? pos_reg - off_ext : '0;

    assign marker = (fill_eff >= hfbf_pkg::MARKER_FILL) &&
                    ({hist_eff[23:0], in_byte_reg} == hfbf_pkg::MARKER);

    // search update and result
    always_comb begin
        hist_next       = hist_eff;
        fill_next       = fill_eff;
        best_next       = best_eff;
        best_valid_next = best_valid_eff;
        done_next       = done_eff;
        out_load        = 1'b0;
        m_found_next    = 1'b0;
        m_start_next    = '0;
        if (!done_eff) begin
            // keep the latest start in the segment
            if (hit.hit && (!best_valid_eff || cand >= best_eff)) begin
                best_next       = cand;
                best_valid_next = 1'b1;
            end
            if (marker && best_valid_next) begin
                out_load     = 1'b1;
                m_found_next = 1'b1;
                m_start_next = 32'(best_next);
                done_next    = 1'b1;
            end else begin
                if (marker) begin
                    // empty segment, start over after the marker
                    hist_next       = '0;
                    fill_next       = '0;
                    best_next       = '0;
                    best_valid_next = 1'b0;
                end else begin
                    hist_next = {hist_eff[HIST_W-9:0], in_byte_reg};
                    if (fill_eff != {FILL_W{1'b1}}) begin
                        fill_next = fill_eff + FILL_W'(1);
                    end
                end
                if (in_last_reg) begin
                    // not-found
                    out_load  = 1'b1;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (proc_fire) begin
            m_valid_next = out_load;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg       <= hfbf_pkg::KIND_REQUEST;
            in_valid_reg   <= 1'b0;
            pos_reg        <= '0;
            hist_reg       <= '0;
            fill_reg       <= '0;
            best_reg       <= '0;
            best_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                kind_reg <= cfg_data;
            end
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (s_accept) begin
                pos_reg <= pos_next;
            end
            if (proc_fire) begin
                hist_reg       <= hist_next;
                fill_reg       <= fill_next;
                best_reg       <= best_next;
                best_valid_reg <= best_valid_next;
                done_reg       <= done_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg  <= s_data_byte;
            in_first_reg <= s_first_byte;
            in_last_reg  <= s_last_byte;
        end
        if (proc_fire && out_load) begin
            m_found_reg <= m_found_next;
            m_start_reg <= m_start_next;
        end
    end

    // a pending result always belongs to a finished search
    `HFBF_ASSERT_NOW(a_result_means_done, aclk, aresetn, m_valid_reg, done_reg)
    // bytes of a finished search never produce a result
    `HFBF_ASSERT_NEXT(a_done_is_silent, aclk, aresetn,
        proc_fire && done_reg && !in_first_reg, !m_valid_reg)
    // a full input stage behind a stalled output takes nothing new
    `HFBF_ASSERT_NOW(a_stall_blocks_input, aclk, aresetn,
        in_valid_reg && m_valid_reg && !m_ready, !s_ready)
    // found is only reported with a recorded pattern start
    `HFBF_ASSERT_NOW(a_found_has_start, aclk, aresetn,
        proc_fire && out_load && m_found_next, best_valid_next)

endmodule

### test/http_frame_boundary_finder_tb.sv
module http_frame_boundary_finder_tb;

    // pattern set codes beyond the two the package names
    localparam hfbf_pkg::kind_t KIND_UNKNOWN = 2'd2;
    localparam hfbf_pkg::kind_t KIND_SPARE   = 2'd3;

    localparam logic [7:0]  CR      = 8'h0D;
    localparam logic [7:0]  LF      = 8'h0A;
    localparam logic [31:0] POS_TOP = 32'hFFFF_FFFF;

    // one frame search outcome
    typedef struct {
        logic        found;
        logic [31:0] start;
    } frame_result_t;

    // clock, reset and dut ports
    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_first_byte;
    logic [31:0] s_start_offset;
    logic        s_last_byte;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_found;
    logic [31:0] m_frame_start;

    // request words first, then the two response versions
    string words [11] = '{"GET ", "HEAD ", "POST ", "PUT ", "DELETE ", "CONNECT ",
                          "OPTIONS ", "TRACE ", "PATCH ", "HTTP/1.1 ", "HTTP/1.0 "};
    // near-miss characters so partial words show up often
    string near_chars = "GETHPOSUDLCNRIAT/1.0 ";

    // shadow copy of the finder state
    hfbf_pkg::kind_t shadow_kind;
    logic [63:0]     seg_history;
    logic [31:0]     scan_pos;
    logic [2:0]      seg_fill;
    logic [31:0]     latest_start;
    bit              latest_ok;
    bit              search_over;

    // outcomes waiting for the result channel
    frame_result_t pending_frames [$];
    int            error_count = 0;

    // idle knobs, percent per cycle
    int sender_gap_pct = 0;
    int recv_stall_pct = 0;

    always #5 aclk = ~aclk;

    http_frame_boundary_finder u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_first_byte   (s_first_byte),
        .s_start_offset (s_start_offset),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_frame_start  (m_frame_start)
    );

    // receiver back-pressure, changed on the falling edge
    always @(negedge aclk) begin
        m_ready <= !(recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct);
    end

    // word w ends on this byte, all of it inside the current segment
    function automatic bit word_ends_here(input int w, input logic [7:0] cur);
        int len;
        int need;
        len  = words[w].len();
        need = (len - 1 > 7) ? 7 : len - 1;
        if (seg_fill < need)
            return 1'b0;
        if (words[w][len - 1] != cur)
            return 1'b0;
        for (int k = 1; k < len; k++) begin
            if (words[w][len - 1 - k] != seg_history[8 * (k - 1) +: 8])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // advance the shadow finder by one accepted byte
    task automatic track_byte(input logic [7:0] cur, input logic first, input logic [31:0] off,
                              input logic last);
        logic [31:0]   st;
        int            lo;
        int            hi;
        int            len;
        bit            marker;
        frame_result_t res;
        if (first) begin
            search_over  = 1'b0;
            seg_history  = '0;
            seg_fill     = '0;
            latest_start = '0;
            latest_ok    = 1'b0;
            scan_pos     = off;
        end else if (scan_pos != POS_TOP) begin
            scan_pos = scan_pos + 32'd1;
        end
        // a finished search ignores everything up to the next first byte
        if (search_over)
            return;
        case (shadow_kind)
            hfbf_pkg::KIND_REQUEST: begin
                lo = 0;
                hi = 8;
            end
            hfbf_pkg::KIND_RESPONSE: begin
                lo = 9;
                hi = 10;
            end
            default: begin
                lo = 0;
                hi = -1;
            end
        endcase
        for (int w = lo; w <= hi; w++) begin
            if (word_ends_here(w, cur)) begin
                len = words[w].len();
                st  = (scan_pos >= 32'(len - 1)) ? scan_pos - 32'(len - 1) : '0;
                if (!latest_ok || st >= latest_start) begin
                    latest_start = st;
                    latest_ok    = 1'b1;
                end
            end
        end
        marker = seg_fill >= 3 && cur == LF && seg_history[7:0] == CR &&
                 seg_history[15:8] == LF && seg_history[23:16] == CR;
        if (marker) begin
            if (latest_ok) begin
                res.found = 1'b1;
                res.start = latest_start;
                pending_frames.push_back(res);
                search_over = 1'b1;
                return;
            end
            // segment with no start word is dropped
            seg_history  = '0;
            seg_fill     = '0;
            latest_start = '0;
            latest_ok    = 1'b0;
        end else begin
            seg_history = {seg_history[55:0], cur};
            if (seg_fill < 3'd7)
                seg_fill = seg_fill + 3'd1;
        end
        if (last) begin
            res.found = 1'b0;
            res.start = '0;
            pending_frames.push_back(res);
            search_over = 1'b1;
        end
    endtask

    // compare every result transaction with the oldest pending outcome
    always @(posedge aclk) begin
        frame_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_frames.size() == 0) begin
                $display("%0t: result with nothing pending: found=%0b frame_start=%0h",
                         $time, m_found, m_frame_start);
                error_count++;
            end else begin
                want = pending_frames.pop_front();
                if (m_found !== want.found) begin
                    $display("%0t: found wrong: expected %0b, actual %0b",
                             $time, want.found, m_found);
                    error_count++;
                end
                if (m_frame_start !== want.start) begin
                    $display("%0t: frame_start wrong: expected %0h, actual %0h",
                             $time, want.start, m_frame_start);
                    error_count++;
                end
            end
        end
    end

    // one byte transaction; called and returns on a falling edge
    task automatic send_byte(input logic [7:0] cur, input logic first, input logic [31:0] off,
                             input logic last);
        // sender gaps
        while (sender_gap_pct > 0 && $urandom_range(0, 99) < sender_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_data_byte    <= cur;
        s_first_byte   <= first;
        s_start_offset <= off;
        s_last_byte    <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        track_byte(cur, first, off, last);
        @(negedge aclk);
    endtask

    // a string as consecutive bytes, first flag on the opening byte only
    task automatic send_text(input string text, input logic first, input logic [31:0] off,
                             input logic last_at_end);
        for (int i = 0; i < text.len(); i++)
            send_byte(text[i], first && i == 0, off, last_at_end && i == text.len() - 1);
    endtask

    // drain pending results, then give the pipeline time to go quiet
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // register write; only called while nothing is in flight
    task automatic write_kind(input hfbf_pkg::kind_t kind);
        cfg_valid <= 1'b1;
        cfg_data  <= kind;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        shadow_kind = kind;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] filler_byte();
        case ($urandom_range(0, 5))
            0: return 8'($urandom_range(0, 255));
            1: return CR;
            2: return LF;
            3: return 8'h00;
            default: return near_chars[$urandom_range(0, near_chars.len() - 1)];
        endcase
    endfunction

    // mostly words of the active set, some from the other one
    function automatic int pick_word(input hfbf_pkg::kind_t kind);
        if (kind == hfbf_pkg::KIND_REQUEST && $urandom_range(0, 99) < 85)
            return $urandom_range(0, 8);
        if (kind == hfbf_pkg::KIND_RESPONSE && $urandom_range(0, 99) < 85)
            return $urandom_range(9, 10);
        return $urandom_range(0, 10);
    endfunction

    // after reset, bytes without a first flag count on from position 1;
    // the byte after the result belongs to a done search and is dropped
    // (octal escapes give the crlfcrlf marker)
    task automatic test_no_first_byte();
        send_text("GET \015\012\015\012", 1'b0, 32'h0, 1'b1);
        send_byte("G", 1'b0, 32'hFFFF_FFFF, 1'b1);
        settle();
    endtask

    // response word starting just below the top, position pinned at the top
    task automatic test_position_saturation();
        write_kind(hfbf_pkg::KIND_RESPONSE);
        send_text("HTTP/1.1 \015\012\015\012", 1'b1, 32'hFFFF_FFFA, 1'b1);
        settle();
    endtask

    // unknown pattern set never matches, extreme byte values
    task automatic test_unknown_kind();
        write_kind(KIND_UNKNOWN);
        send_byte(8'h00, 1'b1, 32'hFFFF_FFFF, 1'b0);
        send_byte(8'hFF, 1'b0, 32'h0000_0000, 1'b1);
        settle();
    endtask

    // random buffers built from segments of filler, words and markers
    task automatic test_random_traffic(input hfbf_pkg::kind_t kind, input int gap,
                                       input int stall, input int n_items);
        logic [7:0]  frame_bytes [$];
        logic [31:0] off;
        logic        first_flag;
        logic        last_flag;
        int          sent;
        int          w;
        sender_gap_pct = gap;
        recv_stall_pct = stall;
        write_kind(kind);
        sent = 0;
        while (sent < n_items) begin
            frame_bytes.delete();
            for (int s = $urandom_range(1, 3); s > 0; s--) begin
                repeat ($urandom_range(0, 4)) frame_bytes.push_back(filler_byte());
                repeat ($urandom_range(0, 2)) begin
                    w = pick_word(kind);
                    for (int i = 0; i < words[w].len(); i++)
                        frame_bytes.push_back(words[w][i]);
                    repeat ($urandom_range(0, 2)) frame_bytes.push_back(filler_byte());
                end
                if ($urandom_range(0, 99) < 75) begin
                    frame_bytes.push_back(CR);
                    frame_bytes.push_back(LF);
                    frame_bytes.push_back(CR);
                    frame_bytes.push_back(LF);
                end
            end
            if (frame_bytes.size() == 0)
                frame_bytes.push_back(filler_byte());
            case ($urandom_range(0, 9))
                0: off = 32'h0;
                1: off = POS_TOP - 32'($urandom_range(0, 40));
                2: off = $urandom;
                default: off = 32'($urandom_range(0, 1000));
            endcase
            for (int i = 0; i < frame_bytes.size(); i++) begin
                // a buffer now and then continues the previous search
                if (i == 0)
                    first_flag = (sent == 0) || ($urandom_range(0, 9) != 0);
                else
                    first_flag = ($urandom_range(0, 99) < 2);
                last_flag = (i == frame_bytes.size() - 1) || ($urandom_range(0, 99) < 2);
                send_byte(frame_bytes[i], first_flag,
                          first_flag ? ((i == 0) ? off : $urandom) : $urandom, last_flag);
                sent++;
            end
        end
        settle();
    endtask

    initial begin
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_data_byte    = '0;
        s_first_byte   = 1'b0;
        s_start_offset = '0;
        s_last_byte    = 1'b0;
        // shadow state after reset
        shadow_kind    = hfbf_pkg::KIND_REQUEST;
        seg_history    = '0;
        scan_pos       = '0;
        seg_fill       = '0;
        latest_start   = '0;
        latest_ok      = 1'b0;
        search_over    = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        test_no_first_byte();
        test_position_saturation();
        test_unknown_kind();

        // kind, sender gap pct, receiver stall pct, byte count
        test_random_traffic(hfbf_pkg::KIND_REQUEST,  0,  0,  65);
        test_random_traffic(hfbf_pkg::KIND_RESPONSE, 62, 0,  65);
        test_random_traffic(hfbf_pkg::KIND_REQUEST,  0,  62, 65);
        test_random_traffic(hfbf_pkg::KIND_RESPONSE, 34, 34, 65);
        test_random_traffic(KIND_UNKNOWN,            0,  0,  65);
        test_random_traffic(KIND_SPARE,              34, 34, 65);
        test_random_traffic(hfbf_pkg::KIND_REQUEST,  34, 34, 65);
        test_random_traffic(hfbf_pkg::KIND_RESPONSE, 0,  62, 65);

        settle();
        if (error_count == 0)
            $display("http_frame_boundary_finder: match");
        else
            $display("http_frame_boundary_finder: mismatch");
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial begin
        #2000000;
        $display("http_frame_boundary_finder: mismatch");
        $finish;
    end

endmodule
